/* rtl/core/htoa_pkg.sv */
// Shared types and constants for the hashed record table with overflow area.
// Used by htoa_hash and hashed_table_with_overflow_area. No dependencies.
package htoa_pkg;

    localparam int PRIMARY_SLOTS_DEF = 900;
    localparam int TOTAL_SLOTS_DEF   = 1000;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int YEAR_W   = 16;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 4;
    localparam int POS_W    = 10;
    // slot numbers and counters; holds any slot count up to 65536
    localparam int SLOT_W   = 17;
    localparam int REM_W    = 16;

    // memory entry: used bit, key, year, tag
    localparam int ENT_W    = 1 + KEY_W + YEAR_W + TAG_W;
    localparam int ENT_USED = ENT_W - 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED_HOME = 4'd0;
    localparam logic [STATUS_W-1:0] ST_STORED_OVF  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND_HOME  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND_OVF   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_DEL_HOME    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DEL_OVF     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL        = 4'd8;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 4'd9;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] home;
    } hash_res_t;

endpackage

/* rtl/core/htoa_hash.sv */
// Home slot unit: mixes the key bytes, then reduces modulo PRIMARY_SLOTS by
// reciprocal multiplication and one correcting subtract. Uses htoa_pkg.
module htoa_hash #(
    parameter int PRIMARY_SLOTS = htoa_pkg::PRIMARY_SLOTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [31:0]              key,
    output htoa_pkg::hash_res_t      res
);
    import htoa_pkg::*;

    localparam logic [SLOT_W-1:0] PRIM_C  = SLOT_W'(PRIMARY_SLOTS);
    // floor(2^31 / PRIMARY_SLOTS); the quotient estimate is low by at most one
    localparam logic [31:0]       RECIP_C = 32'((64'd1 << 31) / PRIMARY_SLOTS);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MUL  = 3'd1;
    localparam logic [2:0] H_QP   = 3'd2;
    localparam logic [2:0] H_SUB  = 3'd3;
    localparam logic [2:0] H_FIX  = 3'd4;

    function automatic logic [31:0] mix(input logic [31:0] k);
        logic [31:0] h;
        logic [31:0] c;
        h = '0;
        for (int i = 0; i < 4; i++) begin
            c = {24'd0, k[8*i +: 8]} * 32'(i + 1);
            h = ((h << 5) - h) ^ c;
        end
        return h;
    endfunction

    logic [2:0]        state_reg;
    logic [30:0]       h_reg;
    logic [62:0]       prod_reg;
    logic [31:0]       qp_reg;
    logic [SLOT_W-1:0] diff_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              done_reg;
    logic [31:0]       mixed;
    logic [31:0]       diff_full;
    logic [SLOT_W-1:0] diff_fix;

    assign mixed     = mix(key);
    // true difference lies in [0, 2*PRIMARY_SLOTS), so the low bits suffice
    assign diff_full = {1'b0, h_reg} - qp_reg;
    assign diff_fix  = (diff_reg >= PRIM_C) ? diff_reg - PRIM_C : diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == H_FIX);
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        h_reg     <= mixed[30:0];
                        state_reg <= H_MUL;
                    end
                end
                H_MUL: begin
                    prod_reg  <= 63'(h_reg) * 63'(RECIP_C);
                    state_reg <= H_QP;
                end
                H_QP: begin
                    qp_reg    <= 32'(prod_reg[61:31]) * 32'(PRIMARY_SLOTS);
                    state_reg <= H_SUB;
                end
                H_SUB: begin
                    diff_reg  <= diff_full[SLOT_W-1:0];
                    state_reg <= H_FIX;
                end
                H_FIX: begin
                    rem_reg   <= diff_fix[REM_W-1:0];
                    state_reg <= H_IDLE;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.home = {1'b0, rem_reg};

endmodule

/* rtl/core/hashed_table_with_overflow_area.sv */
// Top level of the hashed record table with a separate overflow area.
// Depends on htoa_pkg and htoa_hash; holds the slot memory.
//
//  channel | ports                                  | direction
//  input   | s_valid s_ready s_kind s_key s_record_* | in
//  result  | m_valid m_ready m_status m_position ... | out
//
// One transaction at a time. An insert with a bad key, or an unused kind, goes
// straight to the finishing step. Otherwise the hash and modulo come first,
// then a check of the home slot and, if it does not match, a scan that reads
// the overflow slots in order, stopping at a match, and drains the read pipeline,
// then the finishing step and a return to idle. After reset a clearing pass
// writes every slot with s_ready low. A stalled result holds the finishing step;
// the slot write happens when the result enters the output register.
module hashed_table_with_overflow_area #(
    parameter int PRIMARY_SLOTS = htoa_pkg::PRIMARY_SLOTS_DEF,
    parameter int TOTAL_SLOTS   = htoa_pkg::TOTAL_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [htoa_pkg::KIND_W-1:0]     s_kind,
    input  logic [htoa_pkg::KEY_W-1:0]      s_key,
    input  logic [htoa_pkg::YEAR_W-1:0]     s_record_year,
    input  logic [htoa_pkg::TAG_W-1:0]      s_record_tag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [htoa_pkg::STATUS_W-1:0]   m_status,
    output logic [htoa_pkg::POS_W-1:0]      m_position,
    output logic [htoa_pkg::YEAR_W-1:0]     m_found_year,
    output logic [htoa_pkg::TAG_W-1:0]      m_found_tag
);
    import htoa_pkg::*;

    localparam int IW = $clog2(TOTAL_SLOTS);
    localparam logic [SLOT_W-1:0] TOTAL_C = SLOT_W'(TOTAL_SLOTS);
    localparam logic [SLOT_W-1:0] PRIM_C  = SLOT_W'(PRIMARY_SLOTS);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_HASH     = 3'd2;
    localparam logic [2:0] S_HOME_CHK = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [ENT_W-1:0] mem [TOTAL_SLOTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [2:0]          state_reg;
    logic [SLOT_W-1:0]   clr_addr_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                direct_reg;
    logic [STATUS_W-1:0] direct_status_reg;
    logic [SLOT_W-1:0]   home_reg;
    logic                home_free_reg;
    logic                hit_reg;
    logic                hit_home_reg;
    logic [SLOT_W-1:0]   hit_addr_reg;
    logic [YEAR_W-1:0]   hit_year_reg;
    logic [TAG_W-1:0]    hit_tag_reg;
    logic                free_found_reg;
    logic [SLOT_W-1:0]   free_addr_reg;
    logic [SLOT_W-1:0]   scan_addr_reg;
    logic                pend_valid_reg;
    logic [SLOT_W-1:0]   pend_addr_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [YEAR_W-1:0]   fyear_reg;
    logic [TAG_W-1:0]    ftag_reg;

    hash_res_t           hres;
    logic                hash_start;
    logic                accept;
    logic                key_ok;
    logic                rd_used;
    logic                rd_match;
    logic                scan_issue;
    logic                out_free;

    logic [STATUS_W-1:0] fin_status;
    logic [SLOT_W-1:0]   fin_pos;
    logic [YEAR_W-1:0]   fin_year;
    logic [TAG_W-1:0]    fin_tag;
    logic                fin_wr;
    logic                fin_used;

    htoa_hash #(
        .PRIMARY_SLOTS(PRIMARY_SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_key),
        .res     (hres)
    );

    always_comb begin
        key_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (s_key[8*i +: 8] < 8'h41 || s_key[8*i +: 8] > 8'h5A) begin
                key_ok = 1'b0;
            end
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign hash_start = accept && (s_kind == KIND_SEARCH || s_kind == KIND_DELETE ||
                                   (s_kind == KIND_INSERT && key_ok));
    assign rd_used    = rd_data_reg[ENT_USED];
    assign rd_match   = rd_used && (rd_data_reg[ENT_USED-1 -: KEY_W] == key_reg);
    assign scan_issue = (scan_addr_reg < TOTAL_C);
    assign out_free   = !m_valid_reg || m_ready;

    // result and slot update at the finishing step
    always_comb begin
        fin_status = ST_NOT_FOUND;
        fin_pos    = '0;
        fin_year   = '0;
        fin_tag    = '0;
        fin_wr     = 1'b0;
        fin_used   = 1'b0;
        if (direct_reg) begin
            fin_status = direct_status_reg;
        end else if (kind_reg == KIND_INSERT) begin
            if (hit_reg) begin
                fin_status = ST_DUPLICATE;
            end else if (home_free_reg) begin
                fin_status = ST_STORED_HOME;
                fin_pos    = home_reg;
                fin_wr     = 1'b1;
                fin_used   = 1'b1;
            end else if (free_found_reg) begin
                fin_status = ST_STORED_OVF;
                fin_pos    = free_addr_reg;
                fin_wr     = 1'b1;
                fin_used   = 1'b1;
            end else begin
                fin_status = ST_FULL;
            end
        end else if (hit_reg) begin
            fin_pos = hit_addr_reg;
            if (kind_reg == KIND_SEARCH) begin
                fin_status = hit_home_reg ? ST_FOUND_HOME : ST_FOUND_OVF;
                fin_year   = hit_year_reg;
                fin_tag    = hit_tag_reg;
            end else begin
                fin_status = hit_home_reg ? ST_DEL_HOME : ST_DEL_OVF;
                fin_wr     = 1'b1;
            end
        end
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = fin_pos[IW-1:0];
        wr_data = {fin_used, key_reg, year_reg, tag_reg};
        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg[IW-1:0];
                wr_data = '0;
            end
            S_HASH: begin
                rd_en   = hres.done && (hres.home < TOTAL_C);
                rd_addr = hres.home[IW-1:0];
            end
            S_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = scan_addr_reg[IW-1:0];
            end
            S_FINISH: begin
                wr_en = fin_wr && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // the finishing step loads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
                    if (clr_addr_reg == TOTAL_C - SLOT_W'(1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        kind_reg       <= s_kind;
                        key_reg        <= s_key;
                        year_reg       <= s_record_year;
                        tag_reg        <= s_record_tag;
                        hit_reg        <= 1'b0;
                        hit_home_reg   <= 1'b0;
                        free_found_reg <= 1'b0;
                        home_free_reg  <= 1'b0;
                        direct_reg     <= !hash_start;
                        direct_status_reg <= (s_kind == KIND_INSERT) ? ST_BAD_KEY
                                                                     : ST_NOT_FOUND;
                        state_reg      <= hash_start ? S_HASH : S_FINISH;
                    end
                end
                S_HASH: begin
                    if (hres.done) begin
                        home_reg       <= hres.home;
                        scan_addr_reg  <= PRIM_C;
                        pend_valid_reg <= 1'b0;
                        // a home slot past the end of storage is absent
                        state_reg <= (hres.home < TOTAL_C) ? S_HOME_CHK : S_SCAN;
                    end
                end
                S_HOME_CHK: begin
                    home_free_reg <= !rd_used;
                    if (rd_match) begin
                        hit_reg      <= 1'b1;
                        hit_home_reg <= 1'b1;
                        hit_addr_reg <= home_reg;
                        hit_year_reg <= rd_data_reg[TAG_W +: YEAR_W];
                        hit_tag_reg  <= rd_data_reg[TAG_W-1:0];
                        state_reg    <= S_FINISH;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    pend_valid_reg <= scan_issue;
                    pend_addr_reg  <= scan_addr_reg;
                    if (scan_issue) begin
                        scan_addr_reg <= scan_addr_reg + SLOT_W'(1);
                    end
                    if (pend_valid_reg && rd_match) begin
                        hit_reg      <= 1'b1;
                        hit_addr_reg <= pend_addr_reg;
                        hit_year_reg <= rd_data_reg[TAG_W +: YEAR_W];
                        hit_tag_reg  <= rd_data_reg[TAG_W-1:0];
                        state_reg    <= S_FINISH;
                    end else begin
                        if (pend_valid_reg && !rd_used && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_addr_reg  <= pend_addr_reg;
                        end
                        if (!scan_issue && !pend_valid_reg) begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        status_reg  <= fin_status;
                        pos_reg     <= fin_pos[POS_W-1:0];
                        fyear_reg   <= fin_year;
                        ftag_reg    <= fin_tag;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_position   = pos_reg;
    assign m_found_year = fyear_reg;
    assign m_found_tag  = ftag_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while one is in progress");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_BAD_KEY || m_status == ST_DUPLICATE ||
                    m_status == ST_FULL || m_status == ST_NOT_FOUND)
        |-> m_position == '0)
        else $error("position set on a result without a slot");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_status == ST_FOUND_HOME || m_status == ST_FOUND_OVF)
        |-> m_found_year == '0 && m_found_tag == '0)
        else $error("record data on a result that is not a search hit");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready && !m_valid)
        else $error("activity during the clearing pass");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for hashed_table_with_overflow_area.
// Depends on htoa_pkg and the block RTL; predicts every result in-line.
`timescale 1ns / 1ps

module tb_top;
    import htoa_pkg::*;

    localparam int PRIM  = PRIMARY_SLOTS_DEF;
    localparam int TOTAL = TOTAL_SLOTS_DEF;

    // kind code with no operation behind it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [YEAR_W-1:0]   year;
        logic [TAG_W-1:0]    tag;
    } answer_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [KEY_W-1:0]    s_key = '0;
    logic [YEAR_W-1:0]   s_record_year = '0;
    logic [TAG_W-1:0]    s_record_tag = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [POS_W-1:0]    m_position;
    logic [YEAR_W-1:0]   m_found_year;
    logic [TAG_W-1:0]    m_found_tag;

    // shadow copy of the table
    logic              tbl_used [TOTAL];
    logic [KEY_W-1:0]  tbl_key  [TOTAL];
    logic [YEAR_W-1:0] tbl_year [TOTAL];
    logic [TAG_W-1:0]  tbl_tag  [TOTAL];

    answer_t       pending_answers[$];
    logic [31:0]   stored_keys[$];
    int            mismatches = 0;
    bit            sending_done = 0;

    hashed_table_with_overflow_area u_top (.*);

    always #2 aclk = ~aclk;

    function automatic int home_slot(input logic [31:0] key);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < 4; i++)
            h = (h * 32'd31) ^ (32'(key[8*i +: 8]) * 32'(i + 1));
        return int'((h & 32'h7FFF_FFFF) % PRIM);
    endfunction

    function automatic bit key_ok(input logic [31:0] key);
        for (int i = 0; i < 4; i++)
            if (key[8*i +: 8] < 8'h41 || key[8*i +: 8] > 8'h5A) return 0;
        return 1;
    endfunction

    function automatic answer_t table_apply(input logic [KIND_W-1:0] kind,
            input logic [31:0] key, input logic [15:0] yr, input logic [31:0] tg);
        answer_t a;
        int      home;
        int      hit;
        bit      dup;
        bit      at_home;
        a = '0;
        a.status = ST_NOT_FOUND;
        home = home_slot(key);
        if (kind == KIND_INSERT) begin
            if (!key_ok(key)) begin
                a.status = ST_BAD_KEY;
            end else begin
                dup = 0;
                for (int s = 0; s < TOTAL; s++)
                    if (tbl_used[s] && tbl_key[s] == key) dup = 1;
                hit = -1;
                if (dup) begin
                    a.status = ST_DUPLICATE;
                end else if (home < TOTAL && !tbl_used[home]) begin
                    hit = home;
                    a.status = ST_STORED_HOME;
                end else begin
                    a.status = ST_FULL;
                    for (int s = PRIM; s < TOTAL; s++)
                        if (!tbl_used[s] && hit < 0) begin
                            hit = s;
                            a.status = ST_STORED_OVF;
                        end
                end
                if (hit >= 0) begin
                    tbl_used[hit] = 1;
                    tbl_key[hit]  = key;
                    tbl_year[hit] = yr;
                    tbl_tag[hit]  = tg;
                    a.position = POS_W'(hit);
                end
            end
        end else if (kind == KIND_SEARCH || kind == KIND_DELETE) begin
            at_home = home < TOTAL && tbl_used[home] && tbl_key[home] == key;
            hit = at_home ? home : -1;
            if (!at_home)
                for (int s = PRIM; s < TOTAL; s++)
                    if (hit < 0 && tbl_used[s] && tbl_key[s] == key) hit = s;
            if (hit >= 0) begin
                a.position = POS_W'(hit);
                if (kind == KIND_SEARCH) begin
                    a.status = at_home ? ST_FOUND_HOME : ST_FOUND_OVF;
                    a.year   = tbl_year[hit];
                    a.tag    = tbl_tag[hit];
                end else begin
                    a.status = at_home ? ST_DEL_HOME : ST_DEL_OVF;
                    tbl_used[hit] = 0;
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // burst/gap sender; valid stays high between transactions of a burst
    int burst_left = 0;
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [31:0] key,
            input logic [15:0] yr, input logic [31:0] tg);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20)) : 0;
            burst_left = int'($urandom_range(1, 12));
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_key         <= key;
        s_record_year <= yr;
        s_record_tag  <= tg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_answers.insert(pending_answers.size(), table_apply(kind, key, yr, tg));
        if (kind == KIND_INSERT && key_ok(key)) stored_keys.insert(stored_keys.size(), key);
    endtask

    // receiver stall pattern
    int cyc = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if ((cyc / 2000) % 3 == 2) m_ready <= 1'b1;
        else m_ready <= ((cyc * 7) % 11 < 6) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_status), 32'd0);
            end else begin
                want = pending_answers.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_position !== want.position)
                    report_mismatch("position", 32'(m_position), 32'(want.position));
                if (m_found_year !== want.year)
                    report_mismatch("year", 32'(m_found_year), 32'(want.year));
                if (m_found_tag !== want.tag) report_mismatch("tag", m_found_tag, want.tag);
            end
        end
    end

    function automatic logic [31:0] letters_key();
        return {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
    endfunction

    function automatic logic [31:0] known_key();
        if (stored_keys.size() == 0) return letters_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    task automatic test_directed();
        send_op(KIND_INSERT, "AAAA", 16'h0000, 32'h0000_0000);
        send_op(KIND_INSERT, "ZZZZ", 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, "AAAA", 16'h1234, 32'h1);          // duplicate
        send_op(KIND_INSERT, "AAA@", 16'h1, 32'h2);             // below A
        send_op(KIND_INSERT, "[AAA", 16'h1, 32'h2);             // above Z
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 16'h1, 32'h2);
        send_op(KIND_INSERT, 32'h0, 16'h1, 32'h2);
        send_op(KIND_SEARCH, "AAAA", 16'd0, 32'd0);
        send_op(KIND_SEARCH, "ZZZZ", 16'd0, 32'd0);
        send_op(KIND_SEARCH, "QQQQ", 16'd0, 32'd0);
        send_op(KIND_SEARCH, 32'hFFFF_FFFF, 16'd0, 32'd0);      // non-letter search
        send_op(KIND_DELETE, 32'h0000_0000, 16'd0, 32'd0);      // non-letter delete
        send_op(KIND_UNUSED, "AAAA", 16'hFFFF, 32'hFFFF_FFFF);
        send_op(KIND_DELETE, "AAAA", 16'd0, 32'd0);
        send_op(KIND_DELETE, "AAAA", 16'd0, 32'd0);
        send_op(KIND_SEARCH, "AAAA", 16'd0, 32'd0);
    endtask

    // insert 520 letter keys to push records into the overflow area, then search or delete inserted keys 60 times
    task automatic test_overflow_fill();
        int n;
        n = 0;
        while (n < 520) begin
            send_op(KIND_INSERT, letters_key(), 16'($urandom), $urandom);
            n++;
        end
        for (int i = 0; i < 60; i++)
            send_op($urandom_range(0, 1) ? KIND_SEARCH : KIND_DELETE, known_key(),
                    16'd0, 32'd0);
    endtask

    task automatic test_random_mix();
        logic [KIND_W-1:0] k;
        logic [31:0]       key;
        for (int i = 0; i < 150; i++) begin
            k = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0: key = $urandom;
                1, 2, 3: key = letters_key();
                default: key = known_key();
            endcase
            send_op(k, key, 16'($urandom), $urandom);
        end
    endtask

    initial begin
        for (int s = 0; s < TOTAL; s++) tbl_used[s] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_mix();
        test_overflow_fill();
        test_random_mix();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/htoa_pkg.sv
rtl/core/htoa_hash.sv
rtl/core/hashed_table_with_overflow_area.sv
tb/tb_top.sv
